// ----- src/ampd_pkg.sv -----
// Package for the accelerometer magnitude peak detector.
// Holds payload types, register indexes and sizing constants; depends on nothing.
package ampd_pkg;
  localparam int WINDOW_MAX = 64;
  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int MAG_W = 20;
  localparam int SUM_W = MAG_W + IDX_W;
  localparam int SQ_W = 42;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_MAX) * SUM_W'(MAG_MAX);
  localparam int CFG_W = 20;
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_TEMPO = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0] sample_index;
  } in_item_t;

  typedef struct packed {
    logic [19:0] average;
    logic [19:0] peak_value;
    logic peak_found;
    logic [15:0] peak_count;
  } out_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [31:0] sample_index;
  } mag_item_t;
endpackage

// ----- src/ampd_front.sv -----
// Front part: accepts items and forms the Q.4 magnitude with an iterative square root.
// Depends on ampd_pkg.
module ampd_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ampd_pkg::in_item_t in_data,
  output logic m_valid,
  input  logic m_ready,
  output ampd_pkg::mag_item_t m_data
);
  import ampd_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001, F_SQ = 4'b0010, F_ROOT = 4'b0100, F_DONE = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [SQ_W-1:0] v_r, v_nxt;
  logic [SQ_W-1:0] root_r, root_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic signed [15:0] a_r [3];
  logic [31:0] sq;
  logic [SQ_W-1:0] trial;

  always_comb begin
    sq = 32'(a_r[ax_r] * a_r[ax_r]);
    trial = root_r + bit_r;
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    ax_nxt = ax_r;
    idx_nxt = idx_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          v_nxt = '0;
          ax_nxt = '0;
          idx_nxt = in_data.sample_index;
          state_nxt = F_SQ;
        end
      end
      F_SQ: begin
        v_nxt = v_r + SQ_W'(sq);
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          v_nxt = (v_r + SQ_W'(sq)) << 8;
          root_nxt = '0;
          bit_nxt = SQ_W'(1) << (SQ_W - 2);
          state_nxt = F_ROOT;
        end
      end
      F_ROOT: begin
        if (v_r >= trial) begin
          v_nxt = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) state_nxt = F_DONE;
      end
      F_DONE: begin
        if (m_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    v_r <= v_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
    ax_r <= ax_nxt;
    idx_r <= idx_nxt;
    if (state_r == F_IDLE && in_valid) begin
      a_r[0] <= in_data.accel_x;
      a_r[1] <= in_data.accel_y;
      a_r[2] <= in_data.accel_z;
    end
  end

  assign in_ready = (state_r == F_IDLE);
  assign m_valid = (state_r == F_DONE);
  assign m_data.mag = (root_r > SQ_W'(MAG_MAX)) ? MAG_MAX : root_r[MAG_W-1:0];
  assign m_data.sample_index = idx_r;
endmodule

// ----- src/ampd_queue.sv -----
// Short queue of two magnitude items between front and back parts.
// Depends on ampd_pkg.
module ampd_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic s_valid,
  output logic s_ready,
  input  ampd_pkg::mag_item_t s_data,
  output logic m_valid,
  input  logic m_ready,
  output ampd_pkg::mag_item_t m_data
);
  import ampd_pkg::*;

  mag_item_t buf_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign s_ready = (cnt_r != 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign m_data = buf_r[rp_r];
  assign push = s_valid && s_ready;
  assign pop = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) buf_r[wp_r] <= s_data;
  end
endmodule

// ----- src/ampd_back.sv -----
// Back part: magnitude ring, running sum, serial divider and peak decision.
// Depends on ampd_pkg.
module ampd_back (
  input  logic clk,
  input  logic rst_n,
  input  logic s_valid,
  output logic s_ready,
  input  ampd_pkg::mag_item_t s_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [ampd_pkg::CFG_W-1:0] cfg_wdata,
  output logic out_valid,
  input  logic out_ready,
  output ampd_pkg::out_item_t out_data
);
  import ampd_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001, B_MOD = 7'b0000010, B_RD = 7'b0000100, B_SUM = 7'b0001000,
    B_DIV = 7'b0010000, B_DEC = 7'b0100000, B_OUT = 7'b1000000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic [6:0] win_cfg_r;
  logic [15:0] tempo_r;
  logic [19:0] thresh_r;
  logic [MAG_W-1:0] ring [WINDOW_MAX];
  logic [MAG_W-1:0] old_r;
  logic [SUM_W-1:0] sum_r;
  logic [MAG_W-1:0] prev_avg_r;
  logic prev_rise_r;
  logic [31:0] last_peak_r;
  logic [15:0] peaks_r;
  logic [MAG_W-1:0] mag_r;
  logic [31:0] k_r;
  logic [WIN_W-1:0] win_r;
  logic [31:0] kmod_r;
  logic [IDX_W-1:0] mrem_r;
  logic [32:0] divisor_r;
  logic [SUM_W-1:0] rem_r, quo_r;
  logic [5:0] dcnt_r;
  logic [32:0] cmp;
  logic [SUM_W-1:0] total;
  logic [MAG_W-1:0] avg;
  logic rising, peak;
  out_item_t res_r;
  logic [WIN_W-1:0] win_eff;
  logic [WIN_W-1:0] mt1, mt2;
  logic [IDX_W-1:0] mr1, mr2;
  logic [SUM_W:0] grow, diff;
  logic [SUM_W-1:0] fill_sum, full_sum;

  always_comb begin
    if (win_cfg_r == 7'd0) win_eff = WIN_W'(1);
    else if (win_cfg_r > 7'(WINDOW_MAX)) win_eff = WIN_W'(WINDOW_MAX);
    else win_eff = WIN_W'(win_cfg_r);
  end

  // Ring position: remainder of the index by the window, two index bits a cycle.
  always_comb begin
    mt1 = {mrem_r, kmod_r[31]};
    mr1 = (mt1 >= win_r) ? IDX_W'(mt1 - win_r) : mt1[IDX_W-1:0];
    mt2 = {mr1, kmod_r[30]};
    mr2 = (mt2 >= win_r) ? IDX_W'(mt2 - win_r) : mt2[IDX_W-1:0];
  end

  always_comb begin
    grow = {1'b0, sum_r} + (SUM_W+1)'(mag_r);
    fill_sum = (grow > {1'b0, SUM_MAX}) ? SUM_MAX : grow[SUM_W-1:0];
    diff = (grow >= (SUM_W+1)'(old_r)) ? grow - (SUM_W+1)'(old_r) : '0;
    full_sum = (diff > {1'b0, SUM_MAX}) ? SUM_MAX : diff[SUM_W-1:0];
  end

  always_comb begin
    cmp = 33'({rem_r[SUM_W-2:0], quo_r[SUM_W-1]});
    total = sum_r;
    avg = (quo_r > SUM_W'(MAG_MAX)) ? MAG_MAX : quo_r[MAG_W-1:0];
    rising = (k_r == 32'd0) || (avg >= prev_avg_r);
    peak = prev_rise_r && !rising && (avg > thresh_r) &&
           ({1'b0, k_r} > ({1'b0, last_peak_r} + {17'd0, tempo_r}));
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (s_valid) state_nxt = B_MOD;
      B_MOD: if (dcnt_r == 6'd15) state_nxt = B_RD;
      B_RD: state_nxt = B_SUM;
      B_SUM: state_nxt = B_DIV;
      B_DIV: if (dcnt_r == 6'(SUM_W)) state_nxt = B_DEC;
      B_DEC: state_nxt = B_OUT;
      B_OUT: if (out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      win_cfg_r <= 7'd8;
      tempo_r <= '0;
      thresh_r <= '0;
      sum_r <= '0;
      prev_avg_r <= '0;
      prev_rise_r <= 1'b1;
      last_peak_r <= '0;
      peaks_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: win_cfg_r <= cfg_wdata[6:0];
          REG_TEMPO: tempo_r <= cfg_wdata[15:0];
          REG_THRESH: thresh_r <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      case (state_r)
        B_IDLE: if (s_valid) begin
          mag_r <= s_data.mag;
          k_r <= s_data.sample_index;
          kmod_r <= s_data.sample_index;
          mrem_r <= '0;
          dcnt_r <= '0;
          win_r <= win_eff;
        end
        B_MOD: begin
          mrem_r <= mr2;
          kmod_r <= kmod_r << 2;
          dcnt_r <= dcnt_r + 6'd1;
        end
        B_RD: begin
          old_r <= ring[mrem_r];
        end
        B_SUM: begin
          if (k_r == 32'd0) begin
            sum_r <= SUM_W'(mag_r);
            divisor_r <= 33'd1;
          end else if (k_r < 32'(win_r)) begin
            sum_r <= fill_sum;
            divisor_r <= {1'b0, k_r} + 33'd1;
          end else begin
            sum_r <= full_sum;
            divisor_r <= 33'(win_r);
          end
          ring[mrem_r] <= mag_r;
          rem_r <= '0;
          dcnt_r <= '0;
        end
        B_DIV: begin
          if (dcnt_r == 6'd0) quo_r <= total;
          else begin
            if (cmp >= divisor_r) begin
              rem_r <= SUM_W'(cmp - divisor_r);
              quo_r <= {quo_r[SUM_W-2:0], 1'b1};
            end else begin
              rem_r <= SUM_W'(cmp);
              quo_r <= {quo_r[SUM_W-2:0], 1'b0};
            end
          end
          dcnt_r <= dcnt_r + 6'd1;
        end
        B_DEC: begin
          res_r.average <= avg;
          res_r.peak_value <= peak ? avg : '0;
          res_r.peak_found <= peak;
          if (k_r == 32'd0) begin
            peaks_r <= '0;
            last_peak_r <= '0;
            res_r.peak_count <= '0;
          end else if (peak) begin
            peaks_r <= peaks_r + 16'd1;
            last_peak_r <= k_r;
            res_r.peak_count <= peaks_r + 16'd1;
          end else begin
            res_r.peak_count <= peaks_r;
          end
          prev_avg_r <= avg;
          prev_rise_r <= rising;
        end
        default: ;
      endcase
    end
  end

  assign s_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_data = res_r;
endmodule

// ----- src/accel_magnitude_peak_detector.sv -----
// Top level of the accelerometer magnitude peak detector.
// Depends on ampd_pkg, ampd_front, ampd_queue and ampd_back.
//  channel  ports                       direction
//  in       in_valid/in_ready/in_data   item in
//  out      out_valid/out_ready/out_data result out
//  cfg      cfg_we/cfg_index/cfg_wdata  register write
// The front works on one item at a time: three squaring steps and a 21-step square root.
// The back works on one item at a time: 16 steps for the ring position, a serial
// divider, and steps for accept, ring read, sum, decision and hand-off.
// A two-entry queue lets the front start the next item while the back works.
// Reset is synchronous and active low; a stall on out holds the back, and once
// the queue is full the front and in_ready wait as well.
module accel_magnitude_peak_detector (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ampd_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ampd_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [ampd_pkg::CFG_W-1:0] cfg_wdata
);
  import ampd_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  mag_item_t f_data, b_data;

  ampd_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
    .m_valid(f_valid), .m_ready(f_ready), .m_data(f_data));
  ampd_queue u_queue (.clk, .rst_n, .s_valid(f_valid), .s_ready(f_ready), .s_data(f_data),
    .m_valid(b_valid), .m_ready(b_ready), .m_data(b_data));
  ampd_back u_back (.clk, .rst_n, .s_valid(b_valid), .s_ready(b_ready), .s_data(b_data),
    .cfg_we, .cfg_index, .cfg_wdata, .out_valid, .out_ready, .out_data);
endmodule

// ----- src/ampd_checker.sv -----
// Port checker for the peak detector, bound to the top level.
// Depends on ampd_pkg.
module ampd_props (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input ampd_pkg::out_item_t out_data
);
  import ampd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out item dropped");
  a_pv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.peak_found |-> out_data.peak_value == '0) else $error("peak value");
  a_pf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.peak_found |-> out_data.peak_value == out_data.average)
    else $error("peak value mismatch");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid in reset");
endmodule

bind accel_magnitude_peak_detector ampd_props u_chk (.clk, .rst_n, .out_valid,
  .out_ready, .out_data);
